// ===== design/ir_pulse_distance_frame_transmitter_macros.svh =====
// assertion macros shared by the ir frame transmitter
`ifndef IR_PULSE_DISTANCE_FRAME_TRANSMITTER_MACROS_SVH
`define IR_PULSE_DISTANCE_FRAME_TRANSMITTER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define IPTX_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPTX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/iptx_pkg.sv =====
// shared types and constants for the ir pulse distance frame transmitter
package iptx_pkg;

   localparam int FIELD_BITS_DEFAULT  = 24;
   localparam int TIMER_WIDTH_DEFAULT = 16;

   localparam int REG_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 4;

   // register indexes on the csr port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_HEADER_MARK    = 4'd0,
      REG_HEADER_SPACE   = 4'd1,
      REG_BIT_MARK       = 4'd2,
      REG_ZERO_SPACE     = 4'd3,
      REG_ONE_SPACE      = 4'd4,
      REG_TRAIL_MARK     = 4'd5,
      REG_CARRIER_PERIOD = 4'd6,
      REG_CARRIER_HIGH   = 4'd7
   } iptx_reg_type;

   // reset values, 125 ns tick
   localparam logic [REG_WIDTH-1:0] HEADER_MARK_RESET    = 16'd28000;
   localparam logic [REG_WIDTH-1:0] HEADER_SPACE_RESET   = 16'd13600;
   localparam logic [REG_WIDTH-1:0] BIT_MARK_RESET       = 16'd3600;
   localparam logic [REG_WIDTH-1:0] ZERO_SPACE_RESET     = 16'd3360;
   localparam logic [REG_WIDTH-1:0] ONE_SPACE_RESET      = 16'd10240;
   localparam logic [REG_WIDTH-1:0] TRAIL_MARK_RESET     = 16'd3600;
   localparam logic [REG_WIDTH-1:0] CARRIER_PERIOD_RESET = 16'd210;
   localparam logic [REG_WIDTH-1:0] CARRIER_HIGH_RESET   = 16'd69;

   typedef struct packed {
      logic [REG_WIDTH-1:0] header_mark;
      logic [REG_WIDTH-1:0] header_space;
      logic [REG_WIDTH-1:0] bit_mark;
      logic [REG_WIDTH-1:0] zero_space;
      logic [REG_WIDTH-1:0] one_space;
      logic [REG_WIDTH-1:0] trail_mark;
      logic [REG_WIDTH-1:0] carrier_period;
      logic [REG_WIDTH-1:0] carrier_high;
   } iptx_cfg_type;

   typedef struct packed {
      logic ir_out;
      logic mark;
      logic busy_res;
      logic frame_done;
   } iptx_res_type;

endpackage

// ===== design/ir_pulse_distance_frame_transmitter.sv =====
// top level of the pulse distance ir frame transmitter (48 data bits)
//
// each request on the req_ channel is one time-base tick. a tick with
// req_start_req set while the block is idle latches req_address and
// req_command and starts a frame: header mark, header space, 48 data bits
// lsb first (address then command), trailing mark. starts while busy are
// dropped without sampling the payload.
// every request gives exactly one response on rsp_: ir_out (carrier gated
// by the envelope), mark, busy_res and frame_done (last trailing mark tick).
// each response is registered in the output stage; one request is taken per
// cycle while req_ready is high, that is while the skid register is empty.
// a two-entry output stage (output register plus skid register) lets the
// block take a request while an earlier response still waits; req_ready
// drops only when both entries hold responses.
// timing registers are written on the csr_ port (index, data); csr_ready
// is always high and writes beyond the eight registers are ignored.
// synchronous reset returns the sequencer to idle, empties the output
// stage and reloads the default timing (38 kHz carrier, 125 ns ticks).
`include "ir_pulse_distance_frame_transmitter_macros.svh"

module ir_pulse_distance_frame_transmitter #(
   parameter int FIELD_BITS  = iptx_pkg::FIELD_BITS_DEFAULT,
   parameter int TIMER_WIDTH = iptx_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_start_req,
   input  logic [FIELD_BITS-1:0]                req_address,
   input  logic [FIELD_BITS-1:0]                req_command,
   // per-tick responses
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ir_out,
   output logic                                 rsp_mark,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_frame_done,
   // timing register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iptx_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [iptx_pkg::REG_WIDTH-1:0]       csr_data
);

   iptx_pkg::iptx_cfg_type cfg_ff;
   iptx_pkg::iptx_res_type cur_res;
   iptx_pkg::iptx_res_type out_ff;
   iptx_pkg::iptx_res_type skid_ff;
   logic                   out_valid_ff;
   logic                   skid_valid_ff;
   logic                   req_accept;
   logic                   rsp_take;
   logic                   core_active;

   // timing registers, a write is seen by the next tick
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark    <= iptx_pkg::HEADER_MARK_RESET;
         cfg_ff.header_space   <= iptx_pkg::HEADER_SPACE_RESET;
         cfg_ff.bit_mark       <= iptx_pkg::BIT_MARK_RESET;
         cfg_ff.zero_space     <= iptx_pkg::ZERO_SPACE_RESET;
         cfg_ff.one_space      <= iptx_pkg::ONE_SPACE_RESET;
         cfg_ff.trail_mark     <= iptx_pkg::TRAIL_MARK_RESET;
         cfg_ff.carrier_period <= iptx_pkg::CARRIER_PERIOD_RESET;
         cfg_ff.carrier_high   <= iptx_pkg::CARRIER_HIGH_RESET;
      end else if (csr_valid) begin
         case (iptx_pkg::iptx_reg_type'(csr_index))
            iptx_pkg::REG_HEADER_MARK:    cfg_ff.header_mark    <= csr_data;
            iptx_pkg::REG_HEADER_SPACE:   cfg_ff.header_space   <= csr_data;
            iptx_pkg::REG_BIT_MARK:       cfg_ff.bit_mark       <= csr_data;
            iptx_pkg::REG_ZERO_SPACE:     cfg_ff.zero_space     <= csr_data;
            iptx_pkg::REG_ONE_SPACE:      cfg_ff.one_space      <= csr_data;
            iptx_pkg::REG_TRAIL_MARK:     cfg_ff.trail_mark     <= csr_data;
            iptx_pkg::REG_CARRIER_PERIOD: cfg_ff.carrier_period <= csr_data;
            iptx_pkg::REG_CARRIER_HIGH:   cfg_ff.carrier_high   <= csr_data;
            default: ;
         endcase
      end
   end

   // a request is refused only when both output entries are full
   assign req_ready  = !skid_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_take   = out_valid_ff && rsp_ready;

   // sequencer advances once per accepted tick
   iptx_core #(
      .FIELD_BITS  (FIELD_BITS),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .tick      (req_accept),
      .start_req (req_start_req),
      .address   (req_address),
      .command   (req_command),
      .cfg       (cfg_ff),
      .res       (cur_res),
      .active    (core_active)
   );

   // output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            // skid drains first; no request is taken in this cycle
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         // output held by the receiver, park the new response
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_take) begin
         out_ff <= skid_valid_ff ? skid_ff : cur_res;
      end
      if (out_valid_ff && !rsp_take && req_accept) begin
         skid_ff <= cur_res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ir_out     = out_ff.ir_out;
   assign rsp_mark       = out_ff.mark;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_frame_done = out_ff.frame_done;

   // skid entry is only ever filled behind a held output entry
   `IPTX_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid entry valid while output entry empty")

   // a start taken while idle already drives the header mark
   `IPTX_ASSERT_SAME(a_start_marks, clock, reset,
      req_accept && req_start_req && !core_active, cur_res.mark && cur_res.busy_res,
      "start tick does not drive header mark")

   // the last trailing mark tick returns the sequencer to idle
   `IPTX_ASSERT_NEXT(a_done_idle, clock, reset, req_accept && cur_res.frame_done,
      !core_active, "sequencer still active after frame end")

endmodule

// ===== design/iptx_core.sv =====
// frame sequencer: phase, bit, interval and carrier counters, one step per tick
module iptx_core #(
   parameter int FIELD_BITS  = iptx_pkg::FIELD_BITS_DEFAULT,
   parameter int TIMER_WIDTH = iptx_pkg::TIMER_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   input  logic                   start_req,
   input  logic [FIELD_BITS-1:0]  address,
   input  logic [FIELD_BITS-1:0]  command,
   input  iptx_pkg::iptx_cfg_type cfg,
   output iptx_pkg::iptx_res_type res,
   output logic                   active
);

   localparam int PAYLOAD_W = 2 * FIELD_BITS;
   localparam int BP_W      = $clog2(PAYLOAD_W);
   localparam int CMP_W     = ((TIMER_WIDTH > iptx_pkg::REG_WIDTH) ?
                               TIMER_WIDTH : iptx_pkg::REG_WIDTH) + 1;
   localparam logic [BP_W-1:0] LAST_BIT = BP_W'(PAYLOAD_W - 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HMARK,
      PH_HSPACE,
      PH_BMARK,
      PH_BSPACE,
      PH_TMARK
   } phase_type;

   phase_type              phase_ff, phase_in, cur_phase;
   logic [BP_W-1:0]        bit_pos_ff, bit_pos_in, cur_bp;
   logic [TIMER_WIDTH-1:0] interval_ff, interval_in, cur_ic;
   logic [TIMER_WIDTH-1:0] carrier_ff, carrier_in, cur_cc;
   logic [PAYLOAD_W-1:0]   payload_ff, payload_in, cur_payload;

   logic                          launch;
   logic                          is_mark;
   logic                          interval_end;
   logic                          carrier_wrap;
   logic                          ir;
   logic [iptx_pkg::REG_WIDTH-1:0] len;

   always_comb begin
      launch      = (phase_ff == PH_IDLE) && start_req;
      cur_phase   = launch ? PH_HMARK : phase_ff;
      cur_bp      = launch ? '0 : bit_pos_ff;
      cur_ic      = launch ? '0 : interval_ff;
      cur_cc      = launch ? '0 : carrier_ff;
      cur_payload = launch ? {command, address} : payload_ff;

      is_mark = (cur_phase == PH_HMARK) || (cur_phase == PH_BMARK) ||
                (cur_phase == PH_TMARK);

      case (cur_phase)
         PH_HMARK:  len = cfg.header_mark;
         PH_HSPACE: len = cfg.header_space;
         PH_BMARK:  len = cfg.bit_mark;
         PH_BSPACE: len = cur_payload[cur_bp] ? cfg.one_space : cfg.zero_space;
         default:   len = cfg.trail_mark;
      endcase

      // a zero length behaves as one tick; saturated counter also ends it
      interval_end = (CMP_W'(cur_ic) + CMP_W'(1) >= CMP_W'(len)) || (cur_ic == '1);
      carrier_wrap = (CMP_W'(cur_cc) + CMP_W'(1) >= CMP_W'(cfg.carrier_period)) ||
                     (cur_cc == '1);
      ir = is_mark && (CMP_W'(cur_cc) < CMP_W'(cfg.carrier_high));

      phase_in    = phase_ff;
      bit_pos_in  = bit_pos_ff;
      interval_in = interval_ff;
      carrier_in  = carrier_ff;
      payload_in  = payload_ff;
      res         = '0;

      if (cur_phase != PH_IDLE) begin
         payload_in   = cur_payload;
         bit_pos_in   = cur_bp;
         res.ir_out   = ir;
         res.mark     = is_mark;
         res.busy_res = 1'b1;
         if (is_mark) begin
            carrier_in = carrier_wrap ? '0 : cur_cc + 1'b1;
         end else begin
            carrier_in = cur_cc;
         end
         if (interval_end) begin
            interval_in = '0;
            carrier_in  = '0;
            case (cur_phase)
               PH_HMARK:  phase_in = PH_HSPACE;
               PH_HSPACE: phase_in = PH_BMARK;
               PH_BMARK:  phase_in = PH_BSPACE;
               PH_BSPACE: begin
                  if (cur_bp >= LAST_BIT) begin
                     phase_in = PH_TMARK;
                  end else begin
                     bit_pos_in = cur_bp + 1'b1;
                     phase_in   = PH_BMARK;
                  end
               end
               default: begin
                  phase_in       = PH_IDLE;
                  bit_pos_in     = '0;
                  res.frame_done = 1'b1;
               end
            endcase
         end else begin
            interval_in = cur_ic + 1'b1;
            phase_in    = cur_phase;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_pos_ff  <= '0;
         interval_ff <= '0;
         carrier_ff  <= '0;
         payload_ff  <= '0;
      end else if (tick) begin
         phase_ff    <= phase_in;
         bit_pos_ff  <= bit_pos_in;
         interval_ff <= interval_in;
         carrier_ff  <= carrier_in;
         payload_ff  <= payload_in;
      end
   end

   assign active = (phase_ff != PH_IDLE);

endmodule

// ===== tb/ir_pulse_distance_frame_transmitter_test.sv =====
// self-checking testbench for the pulse distance ir frame transmitter
module ir_pulse_distance_frame_transmitter_test;

   localparam int ADDR_BITS  = iptx_pkg::FIELD_BITS_DEFAULT;
   localparam int FRAME_BITS = 2 * iptx_pkg::FIELD_BITS_DEFAULT;
   localparam int TMR_BITS   = iptx_pkg::TIMER_WIDTH_DEFAULT;
   localparam int REG_BITS   = iptx_pkg::REG_WIDTH;
   localparam int IDX_BITS   = iptx_pkg::CSR_INDEX_WIDTH;
   // far beyond the slowest run with both sides stalling
   localparam longint TIMEOUT = 64'd400_000;

   // frame sequencer phases of the emitter
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_HMARK,
      SEQ_HSPACE,
      SEQ_BMARK,
      SEQ_BSPACE,
      SEQ_TMARK
   } seq_phase_type;

   // one time-base tick as sent on the request channel
   typedef struct {
      logic                 start;
      logic [ADDR_BITS-1:0] address;
      logic [ADDR_BITS-1:0] command;
   } tick_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic                 req_start_req = 1'b0;
   logic [ADDR_BITS-1:0] req_address   = '0;
   logic [ADDR_BITS-1:0] req_command   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic                 rsp_ir_out;
   logic                 rsp_mark;
   logic                 rsp_busy_res;
   logic                 rsp_frame_done;
   logic                 csr_valid     = 1'b0;
   logic                 csr_ready;
   logic [IDX_BITS-1:0]  csr_index     = '0;
   logic [REG_BITS-1:0]  csr_data      = '0;

   // ticks still to be sent and emitter outputs still to be seen
   tick_item_type          pending_ticks[$];
   iptx_pkg::iptx_res_type expected_outputs[$];
   tick_item_type          next_tick;
   iptx_pkg::iptx_res_type oldest_output;
   int                     fail_count    = 0;
   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;

   // emitter state mirrored by the predictor
   seq_phase_type          seq_phase;
   logic [5:0]             bit_idx;
   logic [TMR_BITS-1:0]    ivl_cnt;
   logic [TMR_BITS-1:0]    car_cnt;
   logic [FRAME_BITS-1:0]  frame_bits;
   iptx_pkg::iptx_cfg_type timing;

   ir_pulse_distance_frame_transmitter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_req  (req_start_req),
      .req_address    (req_address),
      .req_command    (req_command),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ir_out     (rsp_ir_out),
      .rsp_mark       (rsp_mark),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_frame_done (rsp_frame_done),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // advance the emitter by one tick and return what it drives on that tick
   function automatic iptx_pkg::iptx_res_type emit_tick(
      input logic start,
      input logic [ADDR_BITS-1:0] address,
      input logic [ADDR_BITS-1:0] command);
      iptx_pkg::iptx_res_type drive;
      logic                   in_mark;
      logic                   last_tick;
      logic [REG_BITS-1:0]    span;
      drive = '0;
      // a start is only seen while idle; the start tick is already header mark
      if (seq_phase == SEQ_IDLE && start) begin
         frame_bits = {command, address};
         seq_phase  = SEQ_HMARK;
         bit_idx    = '0;
         ivl_cnt    = '0;
         car_cnt    = '0;
      end
      if (seq_phase == SEQ_IDLE) begin
         return drive;
      end
      in_mark = (seq_phase == SEQ_HMARK) || (seq_phase == SEQ_BMARK) ||
                (seq_phase == SEQ_TMARK);
      drive.ir_out = in_mark && (car_cnt < timing.carrier_high);
      case (seq_phase)
         SEQ_HMARK:  span = timing.header_mark;
         SEQ_HSPACE: span = timing.header_space;
         SEQ_BMARK:  span = timing.bit_mark;
         SEQ_BSPACE: span = frame_bits[bit_idx] ? timing.one_space : timing.zero_space;
         default:    span = timing.trail_mark;
      endcase
      // zero length behaves as one tick; counter saturation also ends it
      last_tick = ({1'b0, ivl_cnt} + 17'd1 >= {1'b0, span}) || (ivl_cnt == '1);
      if (in_mark) begin
         if (({1'b0, car_cnt} + 17'd1 >= {1'b0, timing.carrier_period}) ||
             (car_cnt == '1)) begin
            car_cnt = '0;
         end else begin
            car_cnt = car_cnt + 1'b1;
         end
      end
      if (last_tick) begin
         ivl_cnt = '0;
         car_cnt = '0;
         case (seq_phase)
            SEQ_HMARK:  seq_phase = SEQ_HSPACE;
            SEQ_HSPACE: seq_phase = SEQ_BMARK;
            SEQ_BMARK:  seq_phase = SEQ_BSPACE;
            SEQ_BSPACE: begin
               if (bit_idx >= FRAME_BITS - 1) begin
                  seq_phase = SEQ_TMARK;
               end else begin
                  bit_idx   = bit_idx + 1'b1;
                  seq_phase = SEQ_BMARK;
               end
            end
            default: begin
               seq_phase         = SEQ_IDLE;
               bit_idx           = '0;
               drive.frame_done  = 1'b1;
            end
         endcase
      end else begin
         ivl_cnt = ivl_cnt + 1'b1;
      end
      drive.mark     = in_mark;
      drive.busy_res = 1'b1;
      return drive;
   endfunction

   // request driver: predicts each accepted tick, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outputs.push_back(emit_tick(req_start_req, req_address, req_command));
         end
         // only touch the channel once the current request is gone
         if (!req_valid || req_ready) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_tick = pending_ticks.pop_front();
               req_valid     <= 1'b1;
               req_start_req <= next_tick.start;
               req_address   <= next_tick.address;
               req_command   <= next_tick.command;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: random back-pressure, in-order compare
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outputs.size() == 0) begin
            $error("response with no tick outstanding");
            fail_count++;
         end else begin
            oldest_output = expected_outputs.pop_front();
            if (rsp_ir_out !== oldest_output.ir_out) begin
               $error("ir_out expected %0b got %0b", oldest_output.ir_out, rsp_ir_out);
               fail_count++;
            end
            if (rsp_mark !== oldest_output.mark) begin
               $error("mark expected %0b got %0b", oldest_output.mark, rsp_mark);
               fail_count++;
            end
            if (rsp_busy_res !== oldest_output.busy_res) begin
               $error("busy_res expected %0b got %0b", oldest_output.busy_res, rsp_busy_res);
               fail_count++;
            end
            if (rsp_frame_done !== oldest_output.frame_done) begin
               $error("frame_done expected %0b got %0b", oldest_output.frame_done,
                      rsp_frame_done);
               fail_count++;
            end
         end
      end
   end

   task automatic push_tick(input logic start, input logic [ADDR_BITS-1:0] address,
                            input logic [ADDR_BITS-1:0] command);
      tick_item_type t;
      t.start   = start;
      t.address = address;
      t.command = command;
      pending_ticks.push_back(t);
   endtask

   // random payload on every tick; start_pct sets how often start is raised
   task automatic queue_ticks(input int count, input int start_pct);
      int i;
      for (i = 0; i < count; i++) begin
         push_tick($urandom_range(99) < start_pct, ADDR_BITS'($urandom),
                   ADDR_BITS'($urandom));
      end
   endtask

   // sampled between edges so nothing races the clocked blocks
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_outputs.size() != 0);
   endtask

   // keep ticking until the frame in flight is over, then let the pipe empty
   task automatic settle_frame();
      wait_drained();
      while (seq_phase != SEQ_IDLE) begin
         queue_ticks(16, 0);
         wait_drained();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input iptx_pkg::iptx_reg_type idx,
                            input logic [REG_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         iptx_pkg::REG_HEADER_MARK:    timing.header_mark    = value;
         iptx_pkg::REG_HEADER_SPACE:   timing.header_space   = value;
         iptx_pkg::REG_BIT_MARK:       timing.bit_mark       = value;
         iptx_pkg::REG_ZERO_SPACE:     timing.zero_space     = value;
         iptx_pkg::REG_ONE_SPACE:      timing.one_space      = value;
         iptx_pkg::REG_TRAIL_MARK:     timing.trail_mark     = value;
         iptx_pkg::REG_CARRIER_PERIOD: timing.carrier_period = value;
         iptx_pkg::REG_CARRIER_HIGH:   timing.carrier_high   = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input iptx_pkg::iptx_cfg_type t);
      write_reg(iptx_pkg::REG_HEADER_MARK,    t.header_mark);
      write_reg(iptx_pkg::REG_HEADER_SPACE,   t.header_space);
      write_reg(iptx_pkg::REG_BIT_MARK,       t.bit_mark);
      write_reg(iptx_pkg::REG_ZERO_SPACE,     t.zero_space);
      write_reg(iptx_pkg::REG_ONE_SPACE,      t.one_space);
      write_reg(iptx_pkg::REG_TRAIL_MARK,     t.trail_mark);
      write_reg(iptx_pkg::REG_CARRIER_PERIOD, t.carrier_period);
      write_reg(iptx_pkg::REG_CARRIER_HIGH,   t.carrier_high);
   endtask

   // short intervals keep frames between about 100 and 210 ticks; carrier sometimes wide
   function automatic iptx_pkg::iptx_cfg_type random_timing();
      iptx_pkg::iptx_cfg_type t;
      t.header_mark  = REG_BITS'($urandom_range(8));
      t.header_space = REG_BITS'($urandom_range(3));
      t.bit_mark     = REG_BITS'($urandom_range(1));
      t.zero_space   = REG_BITS'($urandom_range(1));
      t.one_space    = REG_BITS'($urandom_range(3));
      t.trail_mark   = REG_BITS'($urandom_range(6));
      if ($urandom_range(3) == 0) begin
         t.carrier_period = 16'hFFFF;
      end else begin
         t.carrier_period = REG_BITS'($urandom_range(4));
      end
      if ($urandom_range(3) == 0) begin
         t.carrier_high = REG_BITS'($urandom_range(16'hFFFF, 16'hFFF0));
      end else begin
         t.carrier_high = REG_BITS'($urandom_range(5));
      end
      return t;
   endfunction

   // one random timing set with a short stretch of frequent starts
   task automatic random_run();
      set_timing(random_timing());
      queue_ticks(40, 25);
      settle_frame();
   endtask

   initial begin
      int i;
      seq_phase  = SEQ_IDLE;
      bit_idx    = '0;
      ivl_cnt    = '0;
      car_cnt    = '0;
      frame_bits = '0;
      timing = '{iptx_pkg::HEADER_MARK_RESET, iptx_pkg::HEADER_SPACE_RESET,
                 iptx_pkg::BIT_MARK_RESET, iptx_pkg::ZERO_SPACE_RESET,
                 iptx_pkg::ONE_SPACE_RESET, iptx_pkg::TRAIL_MARK_RESET,
                 iptx_pkg::CARRIER_PERIOD_RESET, iptx_pkg::CARRIER_HIGH_RESET};
      send_idle_pct = 6;
      recv_idle_pct = 66;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // idle ticks at reset timing: all outputs low whatever the payload
      push_tick(1'b0, 24'hFFFFFF, 24'hFFFFFF);
      push_tick(1'b0, 24'h000000, 24'h000000);
      queue_ticks(3, 0);
      wait_drained();

      // zero lengths act as one tick, carrier period below two so ir follows
      // the envelope; starts held high so busy starts are dropped and the
      // next frame begins on the tick after frame_done
      set_timing('{16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd3});
      push_tick(1'b1, 24'h000000, 24'h000000);
      for (i = 0; i < 100; i++) begin
         push_tick(1'b1, 24'hFFFFFF, 24'h000000);
      end
      // hold the sender mid-frame until every output has come back
      wait_drained();

      // high time above period: carrier high through the whole mark
      write_reg(iptx_pkg::REG_CARRIER_PERIOD, 16'd3);
      write_reg(iptx_pkg::REG_CARRIER_HIGH, 16'd7);
      queue_ticks(30, 0);
      wait_drained();

      // zero high time: carrier never high
      write_reg(iptx_pkg::REG_CARRIER_HIGH, 16'd0);
      queue_ticks(30, 0);
      wait_drained();

      // long trailing mark so the carrier wraps inside it
      write_reg(iptx_pkg::REG_CARRIER_HIGH, 16'd1);
      write_reg(iptx_pkg::REG_TRAIL_MARK, 16'd8);
      settle_frame();

      random_run();

      // slow sender, eager receiver
      send_idle_pct = 66;
      recv_idle_pct = 6;
      random_run();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_run();

      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_outputs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT);
      $display("TEST FAILED");
      $finish;
   end

endmodule
